@@ design/bgc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared constants and types of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int MOD_BITS_DEFAULT   = 8;
   localparam int TIMER_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int TICKS_BITS     = 16;

   localparam logic [TICKS_BITS-1:0] LONG_TICKS_RESET   = 16'd350;
   localparam logic [TICKS_BITS-1:0] DOUBLE_TICKS_RESET = 16'd150;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REQUIRED_ON  = 3'd0,
      CSR_REQUIRED_OFF = 3'd1,
      CSR_LONG_ENABLE  = 3'd2,
      CSR_DOUBLE_ENABLE = 3'd3,
      CSR_LONG_TICKS   = 3'd4,
      CSR_DOUBLE_TICKS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_PRESS   = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_PULSE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic                  long_enable;
      logic                  double_enable;
      logic [TICKS_BITS-1:0] long_ticks;
      logic [TICKS_BITS-1:0] double_ticks;
   } ctrl_type;

   typedef struct packed {
      logic       normal_press;
      logic       long_press;
      logic       double_press;
      logic       held_level;
      logic [1:0] gesture_state;
   } result_type;

endpackage

@@ design/bgc_csr.sv @@
// ----------------------------------------------------------------------------
// bgc_csr
// Configuration registers: modifier masks, gesture enables and tick limits.
// ----------------------------------------------------------------------------
module bgc_csr #(
   parameter int MOD_BITS = bgc_pkg::MOD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               write,
   input  logic [bgc_pkg::CSR_INDEX_BITS-1:0] index,
   input  logic [bgc_pkg::CSR_DATA_BITS-1:0]  data,
   output logic [MOD_BITS-1:0]                on_mask,
   output logic [MOD_BITS-1:0]                excl_mask,
   output bgc_pkg::ctrl_type                  ctrl
);

   logic [MOD_BITS-1:0] on_mask_ff;
   logic [MOD_BITS-1:0] excl_mask_ff;
   bgc_pkg::ctrl_type   ctrl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_mask_ff            <= '0;
         excl_mask_ff          <= '0;
         ctrl_ff.long_enable   <= 1'b0;
         ctrl_ff.double_enable <= 1'b0;
         ctrl_ff.long_ticks    <= bgc_pkg::LONG_TICKS_RESET;
         ctrl_ff.double_ticks  <= bgc_pkg::DOUBLE_TICKS_RESET;
      end else if (write) begin
         case (bgc_pkg::csr_index_type'(index))
            bgc_pkg::CSR_REQUIRED_ON: begin
               on_mask_ff <= data[MOD_BITS-1:0];
            end
            bgc_pkg::CSR_REQUIRED_OFF: begin
               excl_mask_ff <= data[MOD_BITS-1:0];
            end
            bgc_pkg::CSR_LONG_ENABLE: begin
               ctrl_ff.long_enable <= data[0];
            end
            bgc_pkg::CSR_DOUBLE_ENABLE: begin
               ctrl_ff.double_enable <= data[0];
            end
            bgc_pkg::CSR_LONG_TICKS: begin
               ctrl_ff.long_ticks <= data[bgc_pkg::TICKS_BITS-1:0];
            end
            bgc_pkg::CSR_DOUBLE_TICKS: begin
               ctrl_ff.double_ticks <= data[bgc_pkg::TICKS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign on_mask   = on_mask_ff;
   assign excl_mask = excl_mask_ff;
   assign ctrl      = ctrl_ff;

endmodule

@@ design/bgc_fsm.sv @@
// ----------------------------------------------------------------------------
// bgc_fsm
// Gesture state machine with saturating tick counter; gives the result of
// the request being accepted and updates its state on acceptance.
// ----------------------------------------------------------------------------
module bgc_fsm #(
   parameter int MOD_BITS   = bgc_pkg::MOD_BITS_DEFAULT,
   parameter int TIMER_BITS = bgc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic [MOD_BITS-1:0] modifiers,
   input  logic [MOD_BITS-1:0] on_mask,
   input  logic [MOD_BITS-1:0] excl_mask,
   input  bgc_pkg::ctrl_type   ctrl,
   output bgc_pkg::result_type result
);

   localparam int CMP_BITS =
      (TIMER_BITS > bgc_pkg::TICKS_BITS) ? TIMER_BITS : bgc_pkg::TICKS_BITS;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_LONG    = 2'd1,
      PHASE_RELEASE = 2'd2,
      PHASE_DOUBLE  = 2'd3
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic                  held_ff, held_in;

   logic                  mods_ok;
   logic                  plain;
   logic [TIMER_BITS-1:0] ticked;
   logic                  long_due;
   logic                  double_due;
   logic                  quick;
   logic                  np, lp, dp;

   assign mods_ok = ((modifiers & on_mask) == on_mask) && ((modifiers & excl_mask) == '0);
   assign plain   = !ctrl.long_enable && !ctrl.double_enable;
   assign ticked  = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign long_due   = CMP_BITS'(ticked) >= CMP_BITS'(ctrl.long_ticks);
   assign double_due = CMP_BITS'(ticked) >= CMP_BITS'(ctrl.double_ticks);
   assign quick      = CMP_BITS'(elapsed_ff) < CMP_BITS'(ctrl.double_ticks);

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      held_in    = held_ff;
      np         = 1'b0;
      lp         = 1'b0;
      dp         = 1'b0;
      case (bgc_pkg::mode_type'(mode))
         bgc_pkg::MODE_TICK: begin
            elapsed_in = ticked;
            if (phase_ff == PHASE_LONG) begin
               if (long_due) begin
                  lp       = 1'b1;
                  phase_in = PHASE_IDLE;
               end
            end else if (phase_ff != PHASE_IDLE) begin
               if (double_due) begin
                  np       = 1'b1;
                  phase_in = PHASE_IDLE;
               end
            end
         end
         bgc_pkg::MODE_PRESS: begin
            if (mods_ok) begin
               if (plain) begin
                  np      = 1'b1;
                  held_in = 1'b1;
               end else if (phase_ff == PHASE_IDLE) begin
                  phase_in   = ctrl.long_enable ? PHASE_LONG : PHASE_RELEASE;
                  elapsed_in = '0;
               end else if (phase_ff == PHASE_DOUBLE) begin
                  dp       = 1'b1;
                  phase_in = PHASE_IDLE;
               end
            end
         end
         bgc_pkg::MODE_RELEASE: begin
            if (plain) begin
               held_in = 1'b0;
            end else if (phase_ff == PHASE_LONG || phase_ff == PHASE_RELEASE) begin
               if (ctrl.double_enable && quick) begin
                  phase_in   = PHASE_DOUBLE;
                  elapsed_in = '0;
               end else begin
                  np       = 1'b1;
                  phase_in = PHASE_IDLE;
               end
            end
         end
         default: begin
            if (mods_ok) begin
               if (!ctrl.double_enable) begin
                  np = 1'b1;
               end else if (phase_ff == PHASE_DOUBLE) begin
                  dp       = 1'b1;
                  phase_in = PHASE_IDLE;
               end else begin
                  phase_in   = PHASE_DOUBLE;
                  elapsed_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         elapsed_ff <= '0;
         held_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         held_ff    <= held_in;
      end
   end

   assign result.normal_press  = np;
   assign result.long_press    = lp;
   assign result.double_press  = dp;
   assign result.held_level    = held_in;
   assign result.gesture_state = phase_in;

endmodule

@@ design/bgc_skid.sv @@
// ----------------------------------------------------------------------------
// bgc_skid
// Two-entry output buffer: result register plus skid register, so a new
// request is taken while a result waits.
// ----------------------------------------------------------------------------
module bgc_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bgc_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bgc_pkg::result_type out_data
);

   logic                out_valid_ff;
   logic                skid_valid_ff;
   bgc_pkg::result_type out_data_ff;
   bgc_pkg::result_type skid_data_ff;
   logic                take;
   logic                drain;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && !skid_valid_ff;
   assign drain    = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || drain) begin
            out_valid_ff  <= skid_valid_ff || take;
            skid_valid_ff <= 1'b0;
         end else if (take) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || drain) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (take && out_valid_ff && !drain) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ design/button_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Sorts button requests into normal, long and double presses for one
// modifier-qualified press group.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   mode, modifiers
//   rsp      out        rsp_valid / rsp_ready   normal/long/double press,
//                                               held level, gesture state
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// one request per cycle while req_ready is high; each result is registered.
// the state update is one pass of the gesture state machine.
// synchronous reset sets state, valid flags and csr registers to defaults.
// a two-entry output buffer keeps req_ready high while one result waits;
// req_ready drops only when both entries are full. csr_ready is always high.
// ----------------------------------------------------------------------------
module button_gesture_classifier #(
   parameter int MOD_BITS   = bgc_pkg::MOD_BITS_DEFAULT,
   parameter int TIMER_BITS = bgc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [MOD_BITS-1:0]                req_modifiers,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_normal_press,
   output logic                               rsp_long_press,
   output logic                               rsp_double_press,
   output logic                               rsp_held_level,
   output logic [1:0]                         rsp_gesture_state,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bgc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bgc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [MOD_BITS-1:0] on_mask;
   logic [MOD_BITS-1:0] excl_mask;
   bgc_pkg::ctrl_type   ctrl;
   bgc_pkg::result_type next_result;
   bgc_pkg::result_type rsp_data;
   logic                accept;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   bgc_csr #(
      .MOD_BITS (MOD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .write     (csr_valid),
      .index     (csr_index),
      .data      (csr_data),
      .on_mask   (on_mask),
      .excl_mask (excl_mask),
      .ctrl      (ctrl)
   );

   bgc_fsm #(
      .MOD_BITS   (MOD_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_mode),
      .modifiers (req_modifiers),
      .on_mask   (on_mask),
      .excl_mask (excl_mask),
      .ctrl      (ctrl),
      .result    (next_result)
   );

   bgc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (next_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_normal_press  = rsp_data.normal_press;
   assign rsp_long_press    = rsp_data.long_press;
   assign rsp_double_press  = rsp_data.double_press;
   assign rsp_held_level    = rsp_data.held_level;
   assign rsp_gesture_state = rsp_data.gesture_state;

   a_one_gesture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_normal_press, rsp_long_press, rsp_double_press}) <= 1)
      else $error("more than one gesture in one response");

   a_resolved_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_long_press || rsp_double_press) |-> rsp_gesture_state == 2'd0)
      else $error("long or double press without returning to idle");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty response register");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request left no response");

endmodule
